/* rtl/core/ais_payload_dearmor_header_macros.svh */
// ----------------------------------------------------------------------------
// ais_payload_dearmor_header_macros
// assertion macros shared by the dearmor block
// ----------------------------------------------------------------------------
`ifndef AIS_PAYLOAD_DEARMOR_HEADER_MACROS_SVH
`define AIS_PAYLOAD_DEARMOR_HEADER_MACROS_SVH

// property that holds at every clock edge outside reset
`define AIS_PDH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication into the next cycle
`define AIS_PDH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ais_pdh_pkg.sv */
// ----------------------------------------------------------------------------
// ais_pdh_pkg
// types and constants of the ais payload dearmor block
// ----------------------------------------------------------------------------
package ais_pdh_pkg;

   localparam int MAX_CHARS    = 256;
   localparam int CNT_W        = $clog2(MAX_CHARS + 2);
   localparam int HEADER_CHARS = 7;
   localparam int MIN_BITS     = 38;
   localparam int BIT_TOTAL_W  = 11;
   localparam int SUM_W        = (CNT_W + 4 > BIT_TOTAL_W + 1) ? CNT_W + 4 : BIT_TOTAL_W + 1;

   localparam logic [7:0] DIGIT_LO  = 8'd48;
   localparam logic [7:0] DIGIT_HI  = 8'd87;
   localparam logic [7:0] LETTER_LO = 8'd96;
   localparam logic [7:0] LETTER_HI = 8'd119;
   localparam logic [7:0] LETTER_OFS = 8'd56;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAR = 2'd1,
      STATUS_TOO_LONG = 2'd2,
      STATUS_TOO_FEW  = 2'd3
   } status_type;

   typedef struct packed {
      logic [5:0] value;
      logic       invalid;
      logic       last;
      logic [2:0] pad;
   } item_type;

endpackage

/* rtl/core/ais_pdh_req_if.sv */
// ----------------------------------------------------------------------------
// ais_pdh_req_if
// request channel: one payload character per request
// ----------------------------------------------------------------------------
interface ais_pdh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ascii_char;
   logic       end_of_payload;
   logic [2:0] pad_bits;

   modport source (output valid, output ascii_char, output end_of_payload,
                   output pad_bits, input ready);
   modport sink   (input valid, input ascii_char, input end_of_payload,
                   input pad_bits, output ready);
endinterface

/* rtl/core/ais_pdh_rsp_if.sv */
// ----------------------------------------------------------------------------
// ais_pdh_rsp_if
// result channel: one result per request
// ----------------------------------------------------------------------------
interface ais_pdh_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  six_bit_value;
   logic        char_invalid;
   logic        message_done;
   logic [1:0]  status;
   logic [5:0]  message_type;
   logic [1:0]  repeat_count;
   logic [29:0] station_id;
   logic [10:0] bit_total;

   modport source (output valid, output six_bit_value, output char_invalid,
                   output message_done, output status, output message_type,
                   output repeat_count, output station_id, output bit_total,
                   input ready);
   modport sink   (input valid, input six_bit_value, input char_invalid,
                   input message_done, input status, input message_type,
                   input repeat_count, input station_id, input bit_total,
                   output ready);
endinterface

/* rtl/core/ais_pdh_front.sv */
// ----------------------------------------------------------------------------
// ais_pdh_front
// accepts requests and de-armors each character into a six-bit value
// ----------------------------------------------------------------------------
module ais_pdh_front (
   ais_pdh_req_if.sink         req_chan,
   input  logic                q_ready,
   output logic                q_push,
   output ais_pdh_pkg::item_type q_item
);

   logic [7:0] c;

   always_comb begin
      c = req_chan.ascii_char;
      q_item.last = req_chan.end_of_payload;
      q_item.pad  = req_chan.pad_bits;
      if (c inside {[ais_pdh_pkg::DIGIT_LO:ais_pdh_pkg::DIGIT_HI]}) begin
         q_item.value   = 6'(c - ais_pdh_pkg::DIGIT_LO);
         q_item.invalid = 1'b0;
      end else if (c inside {[ais_pdh_pkg::LETTER_LO:ais_pdh_pkg::LETTER_HI]}) begin
         q_item.value   = 6'(c - ais_pdh_pkg::LETTER_OFS);
         q_item.invalid = 1'b0;
      end else begin
         q_item.value   = 6'd0;
         q_item.invalid = 1'b1;
      end
   end

   assign req_chan.ready = q_ready;
   assign q_push         = req_chan.valid & q_ready;

endmodule

/* rtl/core/ais_pdh_queue.sv */
// ----------------------------------------------------------------------------
// ais_pdh_queue
// two-entry queue between the classifier and the header tracker
// ----------------------------------------------------------------------------
`include "ais_payload_dearmor_header_macros.svh"

module ais_pdh_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ais_pdh_pkg::item_type push_item,
   output logic                  push_ready,
   input  logic                  pop,
   output logic                  pop_valid,
   output ais_pdh_pkg::item_type pop_item
);

   ais_pdh_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];

   `AIS_PDH_ASSERT(a_count_range, count_ff != 2'd3, "queue count out of range")
   `AIS_PDH_ASSERT(a_pop_nonempty, !pop || count_ff != 2'd0, "pop from empty queue")
   `AIS_PDH_ASSERT_NEXT(a_push_grows, push && !pop, count_ff == $past(count_ff) + 2'd1, "push lost")

endmodule

/* rtl/core/ais_pdh_back.sv */
// ----------------------------------------------------------------------------
// ais_pdh_back
// tracks count, bad flag and header bits, and builds the result register
// ----------------------------------------------------------------------------
`include "ais_payload_dearmor_header_macros.svh"

module ais_pdh_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  ais_pdh_pkg::item_type q_item,
   output logic                  q_pop,
   ais_pdh_rsp_if.source         rsp_chan
);

   localparam int CW = ais_pdh_pkg::CNT_W;
   localparam int SW = ais_pdh_pkg::SUM_W;

   logic [CW-1:0] count_ff, count_in, count_step;
   logic          bad_ff, bad_in, bad_step;
   logic [5:0]    slot_ff [ais_pdh_pkg::HEADER_CHARS];
   logic [5:0]    slot_in [ais_pdh_pkg::HEADER_CHARS];
   logic [5:0]    slot_step [ais_pdh_pkg::HEADER_CHARS];

   logic          rsp_valid_ff, rsp_valid_in;
   logic [5:0]    value_ff;
   logic          invalid_ff;
   logic          done_ff;
   ais_pdh_pkg::status_type status_ff, status_in;
   logic [5:0]    type_ff, type_in;
   logic [1:0]    repeat_ff, repeat_in;
   logic [29:0]   station_ff, station_in;
   logic [10:0]   total_ff, total_in;

   logic [SW-1:0]        count_ext;
   logic signed [SW-1:0] total;
   logic                 too_long;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      count_step = count_ff;
      if (count_ff <= CW'(ais_pdh_pkg::MAX_CHARS)) begin
         count_step = count_ff + CW'(1);
      end
      bad_step = bad_ff | q_item.invalid;
      for (int i = 0; i < ais_pdh_pkg::HEADER_CHARS; i++) begin
         slot_step[i] = slot_ff[i];
      end
      if (count_ff < CW'(ais_pdh_pkg::HEADER_CHARS)) begin
         slot_step[count_ff[2:0]] = q_item.value;
      end

      count_ext = SW'(count_step);
      total     = $signed((count_ext << 2) + (count_ext << 1)) - $signed(SW'(q_item.pad));
      too_long  = count_step > CW'(ais_pdh_pkg::MAX_CHARS);

      status_in  = ais_pdh_pkg::STATUS_OK;
      type_in    = 6'd0;
      repeat_in  = 2'd0;
      station_in = 30'd0;
      total_in   = 11'd0;
      if (q_item.last) begin
         if (too_long) begin
            status_in = ais_pdh_pkg::STATUS_TOO_LONG;
         end else if (bad_step) begin
            status_in = ais_pdh_pkg::STATUS_BAD_CHAR;
         end else if (total < SW'(ais_pdh_pkg::MIN_BITS)) begin
            status_in = ais_pdh_pkg::STATUS_TOO_FEW;
         end else begin
            type_in    = slot_step[0];
            repeat_in  = slot_step[1][5:4];
            station_in = {slot_step[1][3:0], slot_step[2], slot_step[3], slot_step[4],
                          slot_step[5], slot_step[6][5:4]};
            total_in   = total[10:0];
         end
      end

      count_in = count_ff;
      bad_in   = bad_ff;
      for (int i = 0; i < ais_pdh_pkg::HEADER_CHARS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (q_pop) begin
         if (q_item.last) begin
            count_in = '0;
            bad_in   = 1'b0;
            for (int i = 0; i < ais_pdh_pkg::HEADER_CHARS; i++) begin
               slot_in[i] = 6'd0;
            end
         end else begin
            count_in = count_step;
            bad_in   = bad_step;
            for (int i = 0; i < ais_pdh_pkg::HEADER_CHARS; i++) begin
               slot_in[i] = slot_step[i];
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ais_pdh_pkg::HEADER_CHARS; i++) begin
            slot_ff[i] <= 6'd0;
         end
      end else begin
         count_ff     <= count_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ais_pdh_pkg::HEADER_CHARS; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         value_ff   <= q_item.value;
         invalid_ff <= q_item.invalid;
         done_ff    <= q_item.last;
         status_ff  <= status_in;
         type_ff    <= type_in;
         repeat_ff  <= repeat_in;
         station_ff <= station_in;
         total_ff   <= total_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.six_bit_value = value_ff;
   assign rsp_chan.char_invalid  = invalid_ff;
   assign rsp_chan.message_done  = done_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.message_type  = type_ff;
   assign rsp_chan.repeat_count  = repeat_ff;
   assign rsp_chan.station_id    = station_ff;
   assign rsp_chan.bit_total     = total_ff;

   `AIS_PDH_ASSERT_NEXT(a_clear_after_last, q_pop && q_item.last, count_ff == '0 && !bad_ff, "state not cleared after last character")
   `AIS_PDH_ASSERT(a_status_only_on_done, !rsp_valid_ff || done_ff || status_ff == ais_pdh_pkg::STATUS_OK, "status set on a non-final result")
   `AIS_PDH_ASSERT(a_total_only_when_ok, !rsp_valid_ff || status_ff == ais_pdh_pkg::STATUS_OK || total_ff == 11'd0, "bit total on a failed message")
   `AIS_PDH_ASSERT(a_count_saturates, count_ff <= CW'(ais_pdh_pkg::MAX_CHARS + 1), "character count past saturation")

endmodule

/* rtl/core/ais_payload_dearmor_header.sv */
// ----------------------------------------------------------------------------
// ais_payload_dearmor_header
// ais payload de-armoring with message header extraction
// ----------------------------------------------------------------------------
// One request per clock cycle is taken while the queue has room, each
// carrying one payload character, and every request gives one result in
// order. A request enters a two-entry queue in the cycle it is accepted;
// the tracker pops it once the output register is free or being taken,
// and registers its result there. The result register and the queue let
// a new request be accepted while an earlier result waits to be taken, so
// the rate is one request per cycle whenever the result side keeps up. The
// result of the final character carries the status and, when ok, the header
// fields and bit count; the per-message state clears after it.
module ais_payload_dearmor_header (
   input  logic          clock,
   input  logic          reset,
   ais_pdh_req_if.sink   req_chan,
   ais_pdh_rsp_if.source rsp_chan
);

   logic                  q_push;
   logic                  q_ready;
   logic                  q_pop;
   logic                  q_valid;
   ais_pdh_pkg::item_type push_item;
   ais_pdh_pkg::item_type pop_item;

   ais_pdh_front u_front (
      .req_chan (req_chan),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   ais_pdh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (pop_item)
   );

   ais_pdh_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (pop_item),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

/* tb/sv/ais_pdh_result_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ais_pdh_result_check
// watches both channels of the dearmor block, predicts the result of every
// accepted request from its own copy of the message state, and compares each
// accepted result field by field with the oldest prediction
// ----------------------------------------------------------------------------
module ais_pdh_result_check
   import ais_pdh_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   ais_pdh_req_if req_mon,
   ais_pdh_rsp_if rsp_mon,
   output int     failures,
   output int     outstanding
);

   typedef struct packed {
      logic [5:0]  value;
      logic        invalid;
      logic        done;
      status_type  status;
      logic [5:0]  msg_type;
      logic [1:0]  repeat_ind;
      logic [29:0] station;
      logic [10:0] bits;
   } char_result_type;

   logic [CNT_W-1:0] msg_chars;
   logic             msg_bad;
   logic [41:0]      header_acc;
   int               fail_total;
   char_result_type  expected_results[$];

   task automatic report_failure(input string msg);
      if (fail_total < 100) $display("ERROR at %0t: %s", $time, msg);
      fail_total++;
   endtask

   task automatic compare_field(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_failure($sformatf("%s got %0d expected %0d", field, got, want));
   endtask

   function automatic char_result_type decode_char(input logic [7:0] code,
                                                   input logic last,
                                                   input logic [2:0] pad);
      char_result_type r;
      logic [5:0]      v;
      logic            good;
      int              idx;
      int              bit_sum;
      r    = '0;
      v    = '0;
      good = 1'b0;
      idx  = int'(msg_chars);
      if (code >= DIGIT_LO && code <= DIGIT_HI) begin
         v    = 6'(code - DIGIT_LO);
         good = 1'b1;
      end else if (code >= LETTER_LO && code <= LETTER_HI) begin
         v    = 6'(code - LETTER_OFS);
         good = 1'b1;
      end
      // header is kept msb first, first character at the top
      if (idx < HEADER_CHARS) header_acc[41 - 6 * idx -: 6] = v;
      if (idx <= MAX_CHARS) msg_chars = msg_chars + 1'b1;
      if (!good) msg_bad = 1'b1;
      r.value   = v;
      r.invalid = !good;
      if (last) begin
         bit_sum = int'(msg_chars) * 6 - int'(pad);
         r.done  = 1'b1;
         if (int'(msg_chars) > MAX_CHARS) begin
            r.status = STATUS_TOO_LONG;
         end else if (msg_bad) begin
            r.status = STATUS_BAD_CHAR;
         end else if (bit_sum < MIN_BITS) begin
            r.status = STATUS_TOO_FEW;
         end else begin
            r.status     = STATUS_OK;
            r.msg_type   = header_acc[41:36];
            r.repeat_ind = header_acc[35:34];
            r.station    = header_acc[33:4];
            r.bits       = bit_sum[10:0];
         end
         msg_chars  = '0;
         msg_bad    = 1'b0;
         header_acc = '0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      char_result_type want;
      char_result_type predicted;
      if (reset) begin
         msg_chars  = '0;
         msg_bad    = 1'b0;
         header_acc = '0;
         expected_results.delete();
      end else begin
         // results first, so a request taken in this cycle cannot match
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               report_failure("result with no request waiting");
            end else begin
               want = expected_results.pop_front();
               compare_field("six_bit_value", rsp_mon.six_bit_value, want.value);
               compare_field("char_invalid", rsp_mon.char_invalid, want.invalid);
               compare_field("message_done", rsp_mon.message_done, want.done);
               compare_field("status", rsp_mon.status, want.status);
               compare_field("message_type", rsp_mon.message_type, want.msg_type);
               compare_field("repeat_count", rsp_mon.repeat_count, want.repeat_ind);
               compare_field("station_id", rsp_mon.station_id, want.station);
               compare_field("bit_total", rsp_mon.bit_total, want.bits);
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            predicted = decode_char(req_mon.ascii_char, req_mon.end_of_payload,
                                    req_mon.pad_bits);
            expected_results.insert(expected_results.size(), predicted);
         end
      end
      outstanding <= expected_results.size();
      failures    <= fail_total;
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives payload characters into the dearmor block: a few hand-built
// messages at the alphabet edges and status boundaries, then random messages
// of clean, short, noisy and overlong payloads, with random gaps on both
// channels and one long result hold-off; gives the verdict at the end
// ----------------------------------------------------------------------------
module testbench;
   import ais_pdh_pkg::*;

   localparam int ITEM_TARGET = 1450;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_OFF    = 150;

   typedef enum int {
      CONTENT_CLEAN,
      CONTENT_NOISY
   } content_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   failures;
   int   outstanding;
   int   cycle_count = 0;
   int   chars_sent  = 0;
   bit   sender_idles = 1'b1;

   ais_pdh_req_if req_chan ();
   ais_pdh_rsp_if rsp_chan ();

   ais_payload_dearmor_header dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ais_pdh_result_check check_unit (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [7:0] armor_char();
      if ($urandom_range(0, 63) < 40) return DIGIT_LO + 8'($urandom_range(0, 39));
      return LETTER_LO + 8'($urandom_range(0, 23));
   endfunction

   task automatic send_char(input logic [7:0] code, input logic last,
                            input logic [2:0] pad);
      int gap;
      gap = sender_idles ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.ascii_char     <= code;
      req_chan.end_of_payload <= last;
      req_chan.pad_bits       <= pad;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      chars_sent++;
   endtask

   task automatic send_payload(input int len, input content_type content,
                               input logic [2:0] pad);
      logic [7:0] code;
      for (int i = 0; i < len; i++) begin
         code = armor_char();
         if (content == CONTENT_NOISY && $urandom_range(0, 3) == 0)
            code = 8'($urandom_range(0, 255));
         send_char(code, i == len - 1, (i == len - 1) ? pad : 3'($urandom_range(0, 7)));
      end
   endtask

   // result side
   initial begin
      int stall;
      int taken;
      bit stall_on;
      rsp_chan.ready = 1'b0;
      taken    = 0;
      stall_on = 1'b1;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 50 == 0) stall_on = ($urandom_range(0, 2) != 0);
         stall = stall_on ? $urandom_range(0, 4) : 0;
         // long hold-off so the block fills and stalls the request side
         if (taken == 600) stall = HOLD_OFF;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         taken++;
      end
   end

   // request side and verdict
   initial begin
      int pick;
      req_chan.valid          = 1'b0;
      req_chan.ascii_char     = '0;
      req_chan.end_of_payload = 1'b0;
      req_chan.pad_bits       = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // alphabet edges, exactly 38 bits
      send_char(8'd48, 1'b0, 3'd0);
      send_char(8'd87, 1'b0, 3'd7);
      send_char(8'd96, 1'b0, 3'd0);
      send_char(8'd119, 1'b0, 3'd0);
      send_char(8'd119, 1'b0, 3'd0);
      send_char(8'd119, 1'b0, 3'd0);
      send_char(8'd119, 1'b1, 3'd4);
      // one bit short
      repeat (6) send_char(8'd48, 1'b0, 3'd0);
      send_char(8'd48, 1'b1, 3'd5);
      // bytes just outside the alphabet and at both ends of the byte range
      send_char(8'd47, 1'b1, 3'd0);
      send_char(8'd88, 1'b1, 3'd7);
      send_char(8'd95, 1'b0, 3'd0);
      send_char(8'd120, 1'b1, 3'd3);
      send_char(8'd255, 1'b0, 3'd0);
      send_char(8'd0, 1'b1, 3'd0);
      // pad out of range on a lone character
      send_char(8'd119, 1'b1, 3'd6);
      // all ones header
      repeat (6) send_char(8'd119, 1'b0, 3'd0);
      send_char(8'd119, 1'b1, 3'd2);

      // longest ok message, then overlong with bad characters
      send_payload(MAX_CHARS, CONTENT_CLEAN, 3'd0);
      send_payload(MAX_CHARS + 2, CONTENT_NOISY, 3'd1);

      while (chars_sent < ITEM_TARGET) begin
         sender_idles = ($urandom_range(0, 2) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 65)
            send_payload($urandom_range(7, 40), CONTENT_CLEAN, 3'($urandom_range(0, 5)));
         else if (pick < 77)
            send_payload($urandom_range(1, 8), CONTENT_CLEAN, 3'($urandom_range(0, 7)));
         else if (pick < 92)
            send_payload($urandom_range(1, 40), CONTENT_NOISY, 3'($urandom_range(0, 7)));
         else if (pick < 98)
            send_payload($urandom_range(38, 70), CONTENT_CLEAN, 3'($urandom_range(6, 7)));
         else
            send_payload($urandom_range(MAX_CHARS - 2, MAX_CHARS + 2), CONTENT_CLEAN,
                         3'($urandom_range(0, 5)));
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
